// ----- rtl/api_frame_tx_escaper_unit_assert.svh -----
// assertion macros for the api frame transmit escaper
// expects clk and rst_n in the scope where they are used
`ifndef API_FRAME_TX_ESCAPER_UNIT_ASSERT_SVH
`define API_FRAME_TX_ESCAPER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AFTX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define AFTX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/aftx_pkg.sv -----
// shared types, constants and helper functions of the api frame transmit escaper
// no dependencies
package aftx_pkg;

  localparam int MAX_PAYLOAD  = 256;
  localparam int REM_W        = 9;
  localparam int OPTION_COUNT = 14;
  localparam int OPT_IDX_W    = $clog2(OPTION_COUNT);
  localparam logic [OPT_IDX_W-1:0] OPT_LAST = OPT_IDX_W'(OPTION_COUNT - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] START_MARK = 8'h7E;
  localparam logic [7:0] ESC_MARK   = 8'h7D;
  localparam logic [7:0] XON_CHAR   = 8'h11;
  localparam logic [7:0] XOFF_CHAR  = 8'h13;
  localparam logic [7:0] ESC_FLIP   = 8'h20;
  localparam logic [7:0] CSUM_BASE  = 8'hFF;

  localparam logic [7:0]  RST_FRAME_TYPE = 8'h10;
  localparam logic [7:0]  RST_FRAME_ID   = 8'h00;
  localparam logic [63:0] RST_DEST_LONG  = 64'h0000_0000_0000_FFFF;
  localparam logic [15:0] RST_DEST_SHORT = 16'hFFFE;
  localparam logic [7:0]  RST_RADIUS     = 8'h00;
  localparam logic [7:0]  RST_TX_OPTIONS = 8'h43;

  typedef enum logic [2:0] {
    REG_FRAME_TYPE  = 3'd0,
    REG_FRAME_ID    = 3'd1,
    REG_DEST_LONG   = 3'd2,
    REG_DEST_SHORT  = 3'd3,
    REG_RADIUS      = 3'd4,
    REG_TX_OPTIONS  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMD_BEGIN = 3'b001,
    CMD_DATA  = 3'b010,
    CMD_STRAY = 3'b100
  } cmd_kind_t;

  // last: checksum follows this command
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  frame_type;
    logic [7:0]  frame_id;
    logic [63:0] dest_address_long;
    logic [15:0] dest_address_short;
    logic [7:0]  broadcast_radius;
    logic [7:0]  transmit_options;
  } cfg_t;

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == START_MARK) || (b == ESC_MARK) || (b == XON_CHAR) || (b == XOFF_CHAR);
  endfunction

  function automatic logic [7:0] opt_byte(input cfg_t cfg, input logic [OPT_IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = cfg.frame_type;
      4'd1:    b = cfg.frame_id;
      4'd2:    b = cfg.dest_address_long[63:56];
      4'd3:    b = cfg.dest_address_long[55:48];
      4'd4:    b = cfg.dest_address_long[47:40];
      4'd5:    b = cfg.dest_address_long[39:32];
      4'd6:    b = cfg.dest_address_long[31:24];
      4'd7:    b = cfg.dest_address_long[23:16];
      4'd8:    b = cfg.dest_address_long[15:8];
      4'd9:    b = cfg.dest_address_long[7:0];
      4'd10:   b = cfg.dest_address_short[15:8];
      4'd11:   b = cfg.dest_address_short[7:0];
      4'd12:   b = cfg.broadcast_radius;
      4'd13:   b = cfg.transmit_options;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/aftx_front.sv -----
// front end: accepts input items, tracks the open frame and classifies items
// into commands for the back end; uses aftx_pkg
module aftx_front
  import aftx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        q_full,
  output logic        push,
  output cmd_t        push_cmd
);

  logic             frame_open_r, frame_open_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [7:0]       len_sat;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    len_sat = in_tdata[7:0];
    if (32'(in_tdata[7:0]) > MAX_PAYLOAD - 1) begin
      len_sat = 8'(MAX_PAYLOAD - 1);
    end
  end

  always_comb begin
    frame_open_nxt = frame_open_r;
    rem_nxt        = rem_r;
    push_cmd.kind  = CMD_STRAY;
    push_cmd.data  = in_tdata[15:8];
    push_cmd.last  = 1'b0;
    if (!in_tuser) begin
      push_cmd.kind  = CMD_BEGIN;
      push_cmd.data  = len_sat;
      push_cmd.last  = (len_sat == 8'd0);
      rem_nxt        = REM_W'(len_sat);
      frame_open_nxt = (len_sat != 8'd0);
    end else if (!frame_open_r || rem_r == '0) begin
      push_cmd.kind  = CMD_STRAY;
      frame_open_nxt = 1'b0;
    end else begin
      push_cmd.kind = CMD_DATA;
      rem_nxt       = rem_r - REM_W'(1);
      push_cmd.last = (rem_r == REM_W'(1));
      if (rem_r == REM_W'(1)) begin
        frame_open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      rem_r        <= '0;
    end else if (push) begin
      frame_open_r <= frame_open_nxt;
      rem_r        <= rem_nxt;
    end
  end

endmodule

// ----- rtl/aftx_queue.sv -----
// two-entry command queue between front and back end
// uses aftx_pkg
module aftx_queue
  import aftx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

endmodule

// ----- rtl/aftx_back.sv -----
// back end: steps through the line bytes of each command, escapes them,
// keeps the checksum and drives the output register; uses aftx_pkg
module aftx_back
  import aftx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       head_valid,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic [2:0] out_tuser,   // byte_valid, frame_done, stray_error
  output logic       out_tlast    // last_of_run
);

  typedef enum logic [6:0] {
    ST_START  = 7'b0000001,
    ST_LEN_HI = 7'b0000010,
    ST_LEN_LO = 7'b0000100,
    ST_OPT    = 7'b0001000,
    ST_DATA   = 7'b0010000,
    ST_CSUM   = 7'b0100000,
    ST_STRAY  = 7'b1000000
  } step_t;

  step_t                step_r, step_nxt, cur_step;
  logic                 active_r, active_nxt;
  logic                 esc_r, esc_nxt;
  logic [OPT_IDX_W-1:0] opt_idx_r, opt_idx_nxt, cur_idx;
  logic [7:0]           sum_r, sum_nxt;
  logic [15:0]          total;
  logic [7:0]           raw;
  logic                 fire, escapable;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r, byte_nxt;
  logic [2:0]           out_user_r, user_nxt;
  logic                 out_last_r, last_nxt;

  assign fire  = head_valid && (!out_valid_r || out_tready);
  assign total = 16'(head.data) + 16'(OPTION_COUNT);

  always_comb begin
    cur_idx = active_r ? opt_idx_r : '0;
    if (active_r) begin
      cur_step = step_r;
    end else begin
      case (head.kind)
        CMD_BEGIN: cur_step = ST_START;
        CMD_DATA:  cur_step = ST_DATA;
        CMD_STRAY: cur_step = ST_STRAY;
        default:   cur_step = ST_STRAY;
      endcase
    end
  end

  always_comb begin
    case (cur_step)
      ST_START:  raw = START_MARK;
      ST_LEN_HI: raw = total[15:8];
      ST_LEN_LO: raw = total[7:0];
      ST_OPT:    raw = opt_byte(cfg, cur_idx);
      ST_DATA:   raw = head.data;
      ST_CSUM:   raw = CSUM_BASE - sum_r;
      ST_STRAY:  raw = 8'h00;
      default:   raw = 8'h00;
    endcase
    escapable = needs_escape(raw) && (cur_step != ST_START) && (cur_step != ST_STRAY);
  end

  always_comb begin
    step_nxt    = cur_step;
    opt_idx_nxt = cur_idx;
    active_nxt  = 1'b1;
    esc_nxt     = 1'b0;
    sum_nxt     = sum_r;
    pop         = 1'b0;
    byte_nxt    = esc_r && active_r ? raw ^ ESC_FLIP : raw;
    user_nxt    = 3'b001;
    last_nxt    = 1'b0;
    if (escapable && !(esc_r && active_r)) begin
      // prefix byte, same step again for the flipped byte
      byte_nxt = ESC_MARK;
      esc_nxt  = 1'b1;
    end else begin
      case (cur_step)
        ST_START: begin
          sum_nxt  = 8'h00;
          step_nxt = ST_LEN_HI;
        end
        ST_LEN_HI: step_nxt = ST_LEN_LO;
        ST_LEN_LO: begin
          step_nxt    = ST_OPT;
          opt_idx_nxt = '0;
        end
        ST_OPT: begin
          sum_nxt     = sum_r + raw;
          opt_idx_nxt = cur_idx + OPT_IDX_W'(1);
          if (cur_idx == OPT_LAST) begin
            if (head.last) begin
              step_nxt = ST_CSUM;
            end else begin
              active_nxt = 1'b0;
            end
          end
        end
        ST_DATA: begin
          sum_nxt = sum_r + raw;
          if (head.last) begin
            step_nxt = ST_CSUM;
          end else begin
            active_nxt = 1'b0;
          end
        end
        ST_CSUM: begin
          active_nxt = 1'b0;
          user_nxt   = 3'b011;
        end
        ST_STRAY: begin
          active_nxt = 1'b0;
          user_nxt   = 3'b100;
        end
        default: active_nxt = 1'b0;
      endcase
      if (!active_nxt) begin
        pop      = fire;
        last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= byte_nxt;
      out_user_r <= user_nxt;
      out_last_r <= last_nxt;
      step_r     <= step_nxt;
      opt_idx_r  <= opt_idx_nxt;
      sum_r      <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      esc_r       <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        active_r    <= active_nxt;
        esc_r       <= esc_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/api_frame_tx_escaper_unit.sv -----
// Escaped API transmit-frame encoder.
// Input stream: tuser is the action (0 begin a frame, 1 payload byte); tdata carries
//   payload_length in [7:0] and data_byte in [15:8].
// Output stream: one encoded line byte per beat in tdata; tuser bit 0 byte_valid,
//   bit 1 frame_done, bit 2 stray_error; tlast marks the last byte caused by an item.
// Config port: cfg_index selects frame_type (0), frame_id (1), dest_address_long (2),
//   dest_address_short (3), broadcast_radius (4), transmit_options (5); always ready.
//   Other indexes are ignored.
// A begin gives 17 to 33 line bytes, a payload byte 1 to 4 (escaped byte plus an
//   escaped checksum when it ends the frame), a stray byte one error beat.
// The back end emits one line byte per cycle while the receiver is ready; a two-entry
//   command queue lets the front take an item every cycle while it has room. The first
//   byte of an item passes through the queue and then the output register.
// Reset (synchronous, rst_n low) closes any frame, empties the queue and the output
//   register and restores the register defaults.
// When the receiver stalls, the output beat holds; the queue fills and in_tready drops.
module api_frame_tx_escaper_unit
  import aftx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // payload_length, data_byte
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic [2:0]  out_tuser,  // byte_valid, frame_done, stray_error
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  `include "api_frame_tx_escaper_unit_assert.svh"

  cfg_t cfg_r;
  logic push, pop, q_full, head_valid;
  cmd_t push_cmd, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_type         <= RST_FRAME_TYPE;
      cfg_r.frame_id           <= RST_FRAME_ID;
      cfg_r.dest_address_long  <= RST_DEST_LONG;
      cfg_r.dest_address_short <= RST_DEST_SHORT;
      cfg_r.broadcast_radius   <= RST_RADIUS;
      cfg_r.transmit_options   <= RST_TX_OPTIONS;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_FRAME_TYPE: cfg_r.frame_type         <= cfg_data[7:0];
        REG_FRAME_ID:   cfg_r.frame_id           <= cfg_data[7:0];
        REG_DEST_LONG:  cfg_r.dest_address_long  <= cfg_data;
        REG_DEST_SHORT: cfg_r.dest_address_short <= cfg_data[15:0];
        REG_RADIUS:     cfg_r.broadcast_radius   <= cfg_data[7:0];
        REG_TX_OPTIONS: cfg_r.transmit_options   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  aftx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  aftx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  aftx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // checksum byte always closes the run
  `AFTX_ASSERT_SAME(a_done_ends_run, out_tvalid && out_tuser[1], out_tlast, "done without tlast")
  // error beat stands alone and carries no line byte
  `AFTX_ASSERT_SAME(a_stray_alone, out_tvalid && out_tuser[2],
                    out_tlast && !out_tuser[0] && out_tdata == 8'h00, "bad stray beat")
  // an escape prefix is never the last byte of a run
  `AFTX_ASSERT_SAME(a_prefix_not_last, out_tvalid && out_tuser[0] && out_tdata == ESC_MARK,
                    !out_tlast, "escape prefix ends run")
  // queue never overflows: a full queue holds the input off
  `AFTX_ASSERT_SAME(a_full_blocks, q_full, !in_tready, "queue full but ready")

endmodule

// ----- dv/testbench.sv -----
// self-checking bench for api_frame_tx_escaper_unit: directed table, then random frames
// every line byte is checked against an in-bench frame encoder; needs aftx_pkg and the rtl
module testbench
  import aftx_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {
    ACT_BEGIN   = 1'b0,
    ACT_PAYLOAD = 1'b1
  } act_t;

  // how a table row is checked: by the encoder, as a stray error, or with a chosen checksum
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_STRAY,
    ROW_PIN_CSUM
  } row_kind_t;

  typedef struct packed {
    act_t       act;
    logic [7:0] len;
    logic [7:0] dat;  // checksum wanted on ROW_PIN_CSUM rows
    row_kind_t  kind;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       valid;
    logic       done;
    logic       stray;
    logic       last;
  } line_beat_t;

  localparam line_beat_t STRAY_BEAT = '{octet: 8'h00, valid: 1'b0, done: 1'b0,
                                        stray: 1'b1, last: 1'b1};
  localparam int NUM_ROWS = 24;
  localparam stim_row_t PLAN [NUM_ROWS] = '{
    '{ACT_PAYLOAD, 8'h00, 8'h55, ROW_STRAY},    // byte before any frame
    '{ACT_BEGIN,   8'h00, 8'h00, ROW_PREDICT},  // empty payload
    '{ACT_BEGIN,   8'h03, 8'h00, ROW_PREDICT},  // length byte 0x11
    '{ACT_PAYLOAD, 8'h00, 8'h7E, ROW_PREDICT},
    '{ACT_PAYLOAD, 8'h00, 8'h7D, ROW_PREDICT},
    '{ACT_PAYLOAD, 8'h00, 8'h11, ROW_PREDICT},
    '{ACT_PAYLOAD, 8'hFF, 8'hAA, ROW_STRAY},    // byte after a closed frame
    '{ACT_BEGIN,   8'h05, 8'hFF, ROW_PREDICT},  // length byte 0x13
    '{ACT_PAYLOAD, 8'h00, 8'h13, ROW_PREDICT},
    '{ACT_PAYLOAD, 8'h00, 8'h00, ROW_PREDICT},
    '{ACT_BEGIN,   8'h02, 8'h00, ROW_PREDICT},  // abandons the open frame
    '{ACT_PAYLOAD, 8'h00, 8'hFF, ROW_PREDICT},
    '{ACT_PAYLOAD, 8'h00, 8'h7E, ROW_PIN_CSUM},
    '{ACT_BEGIN,   8'hFF, 8'h00, ROW_PREDICT},  // longest payload
    '{ACT_PAYLOAD, 8'h00, 8'h80, ROW_PREDICT},
    '{ACT_BEGIN,   8'h01, 8'h00, ROW_PREDICT},
    '{ACT_PAYLOAD, 8'h00, 8'h7D, ROW_PIN_CSUM},
    '{ACT_BEGIN,   8'h01, 8'h00, ROW_PREDICT},
    '{ACT_PAYLOAD, 8'h00, 8'h11, ROW_PIN_CSUM},
    '{ACT_BEGIN,   8'h01, 8'h00, ROW_PREDICT},
    '{ACT_PAYLOAD, 8'h00, 8'h13, ROW_PIN_CSUM},
    '{ACT_BEGIN,   8'h70, 8'h00, ROW_PREDICT},  // length byte 0x7E
    '{ACT_BEGIN,   8'h6F, 8'h00, ROW_PREDICT},  // length byte 0x7D, left open
    '{ACT_PAYLOAD, 8'h00, 8'h01, ROW_PREDICT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // encoder state mirrored from the block
  cfg_t       regs_shadow;
  logic       frame_open;
  logic [8:0] bytes_left;
  logic [7:0] csum_acc;

  line_beat_t line_bytes_due[$];
  line_beat_t run_beats[$];
  int         items_sent = 0;
  int         mismatches = 0;
  logic       calm = 1'b0;
  logic       hold_off = 1'b0;

  api_frame_tx_escaper_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void push_escaped(input logic [7:0] b, input logic done);
    if (b inside {START_MARK, ESC_MARK, XON_CHAR, XOFF_CHAR}) begin
      run_beats.push_back(line_beat_t'{octet: ESC_MARK, valid: 1'b1, done: 1'b0,
                                       stray: 1'b0, last: 1'b0});
      b = b ^ ESC_FLIP;
    end
    run_beats.push_back(line_beat_t'{octet: b, valid: 1'b1, done: done,
                                     stray: 1'b0, last: 1'b0});
  endfunction

  function automatic void close_frame();
    push_escaped(CSUM_BASE - csum_acc, 1'b1);
    frame_open = 1'b0;
    bytes_left = '0;
  endfunction

  // line bytes caused by one request, left in run_beats
  function automatic void encode_item(input act_t act, input logic [7:0] len_in,
                                      input logic [7:0] dat);
    logic [8:0]   len;
    logic [15:0]  total;
    logic [111:0] opts;
    logic [7:0]   o;
    run_beats.delete();
    if (act == ACT_BEGIN) begin
      len = {1'b0, len_in};
      if (len > 9'(MAX_PAYLOAD - 1)) len = 9'(MAX_PAYLOAD - 1);
      total = 16'(len) + 16'd14;
      opts = {regs_shadow.frame_type, regs_shadow.frame_id, regs_shadow.dest_address_long,
              regs_shadow.dest_address_short, regs_shadow.broadcast_radius,
              regs_shadow.transmit_options};
      run_beats.push_back(line_beat_t'{octet: START_MARK, valid: 1'b1, done: 1'b0,
                                       stray: 1'b0, last: 1'b0});
      push_escaped(total[15:8], 1'b0);
      push_escaped(total[7:0], 1'b0);
      csum_acc = '0;
      for (int i = 0; i < 14; i++) begin
        o = opts[111 - 8*i -: 8];
        push_escaped(o, 1'b0);
        csum_acc = csum_acc + o;
      end
      bytes_left = len;
      frame_open = 1'b1;
      if (bytes_left == 0) close_frame();
    end else if (!frame_open || bytes_left == 0) begin
      frame_open = 1'b0;
      run_beats.push_back(STRAY_BEAT);
    end else begin
      push_escaped(dat, 1'b0);
      csum_acc = csum_acc + dat;
      bytes_left = bytes_left - 9'd1;
      if (bytes_left == 0) close_frame();
    end
    run_beats[run_beats.size() - 1].last = 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("mismatch %s: got %02h, want %02h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    line_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (line_bytes_due.size() == 0) begin
        note_mismatch("unexpected line byte", out_tdata, 8'h00);
      end else begin
        want = line_bytes_due.pop_front();
        if (out_tdata !== want.octet) note_mismatch("out_byte", out_tdata, want.octet);
        if (out_tuser[0] !== want.valid)
          note_mismatch("byte_valid", 8'(out_tuser[0]), 8'(want.valid));
        if (out_tuser[1] !== want.done)
          note_mismatch("frame_done", 8'(out_tuser[1]), 8'(want.done));
        if (out_tuser[2] !== want.stray)
          note_mismatch("stray_error", 8'(out_tuser[2]), 8'(want.stray));
        if (out_tlast !== want.last)
          note_mismatch("last_of_run", 8'(out_tlast), 8'(want.last));
      end
    end
  end

  // receiver: random stalls, none while calm, and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_off && (calm || $urandom_range(99) >= 27);
    end
  end

  initial begin
    wait (items_sent >= 50);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic logic [7:0] any_byte();
    logic [7:0] specials [4];
    specials = '{START_MARK, ESC_MARK, XON_CHAR, XOFF_CHAR};
    if ($urandom_range(99) < 30) return specials[2'($urandom_range(3))];
    return 8'($urandom_range(255));
  endfunction

  // valid stays high into the next request unless a gap is drawn
  task automatic send_item(input act_t act, input logic [7:0] len, input logic [7:0] dat,
                           input logic typed_stray);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 27) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {dat, len};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    encode_item(act, len, dat);
    if (typed_stray) begin
      line_bytes_due.push_back(STRAY_BEAT);
    end else begin
      foreach (run_beats[i]) line_bytes_due.push_back(run_beats[i]);
    end
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (line_bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] reg_word(input int phase, input int r);
    logic [63:0] pat;
    pat = 64'h7E7D_1113_137E_7D11;
    case (phase)
      0:       return '1;
      1:       return '0;
      2:       return (pat << (8 * r)) | (pat >> (64 - 8 * r));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic load_registers(input int phase);
    reg_idx_t   r;
    logic [63:0] d;
    r = r.first();
    do begin
      d = reg_word(phase, int'(r));
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= d;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (r)
        REG_FRAME_TYPE: regs_shadow.frame_type         = d[7:0];
        REG_FRAME_ID:   regs_shadow.frame_id           = d[7:0];
        REG_DEST_LONG:  regs_shadow.dest_address_long  = d;
        REG_DEST_SHORT: regs_shadow.dest_address_short = d[15:0];
        REG_RADIUS:     regs_shadow.broadcast_radius   = d[7:0];
        REG_TX_OPTIONS: regs_shadow.transmit_options   = d[7:0];
        default: ;
      endcase
      r = r.next();
    end while (r != r.first());
    cfg_valid <= 1'b0;
  endtask

  task automatic random_frames(input int quota);
    int stop_at, pick, n, cut;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_item(ACT_PAYLOAD, 8'($urandom_range(255)), any_byte(), 1'b0);
      end else if (pick < 16) begin
        // long frame, a few bytes, then abandoned by whatever begins next
        send_item(ACT_BEGIN, 8'($urandom_range(128, 255)), 8'($urandom_range(255)), 1'b0);
        n = $urandom_range(0, 3);
        repeat (n) send_item(ACT_PAYLOAD, 8'($urandom_range(255)), any_byte(), 1'b0);
      end else begin
        n = $urandom_range(0, 6);
        cut = ($urandom_range(99) < 12) ? $urandom_range(0, n) : n;
        send_item(ACT_BEGIN, 8'(n), 8'($urandom_range(255)), 1'b0);
        repeat (cut) send_item(ACT_PAYLOAD, 8'($urandom_range(255)), any_byte(), 1'b0);
      end
    end
  endtask

  initial begin
    logic [7:0] dat;
    regs_shadow = '{frame_type: RST_FRAME_TYPE, frame_id: RST_FRAME_ID,
                    dest_address_long: RST_DEST_LONG, dest_address_short: RST_DEST_SHORT,
                    broadcast_radius: RST_RADIUS, transmit_options: RST_TX_OPTIONS};
    frame_open = 1'b0;
    bytes_left = '0;
    csum_acc   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      dat = PLAN[i].dat;
      // pick the last payload byte so that the checksum comes out as the wanted value
      if (PLAN[i].kind == ROW_PIN_CSUM) dat = CSUM_BASE - PLAN[i].dat - csum_acc;
      send_item(PLAN[i].act, PLAN[i].len, dat, PLAN[i].kind == ROW_STRAY);
    end
    drain();

    // the frame left open above runs on across the first register change
    for (int phase = 0; phase < 5; phase++) begin
      load_registers(phase);
      calm <= (phase == 3);
      random_frames(17);
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
